@@ src/ghfm_pkg.sv @@
// Package for the grid hole filler: sizing constants, register indexes and shared types.
// Used by every module of the block; depends on nothing.
package ghfm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 4;

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int HW  = 16;
    localparam int RBW = $clog2(MAX_RADIUS + 1);
    localparam int DB  = RBW + 1;
    localparam int AW  = $clog2(2 * MAX_RADIUS * (MAX_WIDTH + 1) + 8);
    localparam int PW  = AW + 1;
    localparam int CNW = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int SW  = 32 + CNW + 1;
    localparam int QDEPTH = 2;

    localparam logic [2:0] REG_GRID_WIDTH     = 3'd0;
    localparam logic [2:0] REG_GRID_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_RADIUS         = 3'd2;
    localparam logic [2:0] REG_CIRCULAR_MODE  = 3'd3;
    localparam logic [2:0] REG_DEFAULT_ENABLE = 3'd4;
    localparam logic [2:0] REG_DEFAULT_VALUE  = 3'd5;
    localparam logic [2:0] REG_BAD_VALUE      = 3'd6;

    localparam logic [1:0] ST_COPIED = 2'd0;
    localparam logic [1:0] ST_FILLED = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;

    localparam logic CMD_SAMPLE = 1'b0;

    typedef struct packed {
        logic [WW-1:0]  w;
        logic [HW-1:0]  h;
        logic [RBW-1:0] r;
        logic           circ;
        logic           den;
        logic [31:0]    dval;
        logic [31:0]    bval;
    } cfg_t;

    typedef struct packed {
        logic [AW-1:0] addr;
        logic [CW-1:0] col;
        logic [HW-1:0] row;
        logic          last;
    } job_t;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        logic [32:0]   data;
    } wr_t;

endpackage

@@ src/ghfm_if.sv @@
// Stream channel interfaces for sample beats in and result beats out.
// Depend on nothing but the package-free payload widths given here.
interface ghfm_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] sample_value;
    logic        sample_valid;
    modport source (output valid, command, sample_value, sample_valid, input ready);
    modport sink   (input valid, command, sample_value, sample_valid, output ready);
endinterface

interface ghfm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_value;
    logic [1:0]  out_status;
    logic        out_last;
    modport source (output valid, out_value, out_status, out_last, input ready);
    modport sink   (input valid, out_value, out_status, out_last, output ready);
endinterface

@@ src/grid_hole_fill_mean.sv @@
// Grid hole filler: fills invalid samples of a raster stream with the mean of their
// window. A sample beat passes the front end states (idle, multiply, decide), which write
// the line store and decide whether a result is due; due results queue for the back end.
// A valid centre goes from its centre read straight to the output; an invalid one needs
// (2*radius+1)^2 store reads, one per cycle on the single read port, plus the steps
// around the scan and the bit-serial divider. Results lag input by radius rows
// plus radius samples and drain beats flush the tail. The line store has no reset and
// needs no clearing pass.
// Depends on ghfm_pkg, ghfm_if, ghfm_front, ghfm_queue and ghfm_back.
module grid_hole_fill_mean
    import ghfm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ghfm_in_if.sink     in_ch,
    ghfm_out_if.source  out_ch
);

    logic [10:0] grid_width_reg;
    logic [15:0] grid_height_reg;
    logic [2:0]  radius_reg;
    logic        circular_mode_reg, default_enable_reg;
    logic [31:0] default_value_reg, bad_value_reg;
    logic [2:0]  reg_idx;
    cfg_t        cfg;
    wr_t         wr;
    job_t        fq_job, qb_job;
    logic        fq_valid, fq_ready, qb_valid, qb_ready;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg     <= 11'd1024;
            grid_height_reg    <= 16'd1;
            radius_reg         <= 3'd1;
            circular_mode_reg  <= 1'b0;
            default_enable_reg <= 1'b0;
            default_value_reg  <= '0;
            bad_value_reg      <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_GRID_WIDTH:     grid_width_reg     <= pwdata[10:0];
                REG_GRID_HEIGHT:    grid_height_reg    <= pwdata[15:0];
                REG_RADIUS:         radius_reg         <= pwdata[2:0];
                REG_CIRCULAR_MODE:  circular_mode_reg  <= pwdata[0];
                REG_DEFAULT_ENABLE: default_enable_reg <= pwdata[0];
                REG_DEFAULT_VALUE:  default_value_reg  <= pwdata;
                REG_BAD_VALUE:      bad_value_reg      <= pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_GRID_WIDTH:     prdata = {21'd0, grid_width_reg};
            REG_GRID_HEIGHT:    prdata = {16'd0, grid_height_reg};
            REG_RADIUS:         prdata = {29'd0, radius_reg};
            REG_CIRCULAR_MODE:  prdata = {31'd0, circular_mode_reg};
            REG_DEFAULT_ENABLE: prdata = {31'd0, default_enable_reg};
            REG_DEFAULT_VALUE:  prdata = default_value_reg;
            REG_BAD_VALUE:      prdata = bad_value_reg;
            default:            prdata = '0;
        endcase
    end

    // Out-of-range register values are clamped to the supported range.
    always_comb
    begin
        if (grid_width_reg == '0)
            cfg.w = WW'(1);
        else if (WW'(grid_width_reg) > WW'(MAX_WIDTH))
            cfg.w = WW'(MAX_WIDTH);
        else
            cfg.w = WW'(grid_width_reg);
        cfg.h = (grid_height_reg == '0) ? HW'(1) : grid_height_reg;
        if (radius_reg == '0)
            cfg.r = RBW'(1);
        else if (RBW'(radius_reg) > RBW'(MAX_RADIUS))
            cfg.r = RBW'(MAX_RADIUS);
        else
            cfg.r = RBW'(radius_reg);
        cfg.circ = circular_mode_reg;
        cfg.den  = default_enable_reg;
        cfg.dval = default_value_reg;
        cfg.bval = bad_value_reg;
    end

    ghfm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_ch     (in_ch),
        .wr        (wr),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    ghfm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_job   (fq_job),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_job   (qb_job)
    );

    ghfm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .wr        (wr),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .out_ch    (out_ch)
    );

endmodule

@@ src/ghfm_front.sv @@
// Front end: accepts beats, writes samples to the line store and decides when a result is due.
// Depends on ghfm_pkg and ghfm_in_if.
module ghfm_front
    import ghfm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    ghfm_in_if.sink      in_ch,
    output wr_t          wr,
    output logic         job_valid,
    input  logic         job_ready,
    output job_t         job
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_DEC  = 3'b100
    } fstate_t;

    fstate_t          state_reg, state_next;
    logic [AW-1:0]    wr_addr_reg, out_addr_reg;
    logic [PW-1:0]    pending_reg;
    logic [CW-1:0]    out_col_reg;
    logic [HW-1:0]    out_row_reg;
    logic [HW+WW:0]   idx_reg, last_reg;
    logic [RBW+WW:0]  need_reg;

    logic             accept, due, push;
    logic [HW+WW:0]   rem, need;
    logic             col_wrap, row_wrap;

    assign in_ch.ready = (state_reg == F_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    assign wr.en   = accept && (in_ch.command == CMD_SAMPLE);
    assign wr.addr = wr_addr_reg;
    assign wr.data = {in_ch.sample_valid, in_ch.sample_value};

    assign col_wrap = ({1'b0, out_col_reg} + 1'b1) >= (CW+1)'(cfg.w);
    assign row_wrap = ({1'b0, out_row_reg} + 1'b1) >= {1'b0, cfg.h};

    always_comb
    begin
        rem  = (idx_reg > last_reg) ? '0 : last_reg - idx_reg;
        need = ((HW+WW+1)'(need_reg) < rem) ? (HW+WW+1)'(need_reg) : rem;
        due  = (pending_reg != '0) && ((HW+WW+1)'(pending_reg) >= need + 1'b1);
    end

    assign job_valid = (state_reg == F_DEC) && due;
    assign push      = job_valid && job_ready;
    assign job.addr  = out_addr_reg;
    assign job.col   = out_col_reg;
    assign job.row   = out_row_reg;
    assign job.last  = col_wrap && row_wrap;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (accept) state_next = F_MUL;
            F_MUL:   state_next = F_DEC;
            F_DEC:   if (!due || push) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            wr_addr_reg  <= '0;
            out_addr_reg <= '0;
            pending_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr.en)
            begin
                wr_addr_reg <= wr_addr_reg + 1'b1;
                pending_reg <= pending_reg + 1'b1;
            end
            else if (push)
            begin
                pending_reg <= pending_reg - 1'b1;
            end
            if (push)
            begin
                out_addr_reg <= out_addr_reg + 1'b1;
                if (col_wrap)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= row_wrap ? '0 : out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_reg <= out_col_reg + 1'b1;
                end
            end
        end
    end

    // Products for the readiness test, registered ahead of the compare.
    always_ff @(posedge clk)
    begin
        if (state_reg == F_MUL)
        begin
            idx_reg  <= (HW+WW+1)'(out_row_reg * cfg.w) + (HW+WW+1)'(out_col_reg);
            last_reg <= (HW+WW+1)'(cfg.h * cfg.w) - 1'b1;
            need_reg <= (RBW+WW+1)'(cfg.r * cfg.w) + (RBW+WW+1)'(cfg.r);
        end
    end

endmodule

@@ src/ghfm_queue.sv @@
// Short job queue that decouples the front end from the averaging back end.
// Depends on ghfm_pkg.
module ghfm_queue
    import ghfm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_job,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_job
);

    localparam int QA = $clog2(QDEPTH);

    job_t            slot_reg [QDEPTH];
    logic [QA-1:0]   head_reg, tail_reg;
    logic [QA:0]     count_reg;
    logic            push, pop;

    assign wr_ready = (count_reg != (QA+1)'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = slot_reg[head_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                tail_reg <= (tail_reg == QA'(QDEPTH - 1)) ? '0 : tail_reg + 1'b1;
            if (pop)
                head_reg <= (head_reg == QA'(QDEPTH - 1)) ? '0 : head_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[tail_reg] <= wr_job;
    end

endmodule

@@ src/ghfm_back.sv @@
// Back end: owns the line store, scans the window of an invalid sample and forms the mean.
// Depends on ghfm_pkg and ghfm_out_if.
module ghfm_back
    import ghfm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  wr_t        wr,
    input  logic       job_valid,
    output logic       job_ready,
    input  job_t       job,
    ghfm_out_if.source out_ch
);

    localparam int RD = 1 << AW;
    localparam int DCW = $clog2(SW + 1);

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_CTR  = 7'b0000010,
        B_SCAN = 7'b0000100,
        B_LAST = 7'b0001000,
        B_FIN  = 7'b0010000,
        B_DIV  = 7'b0100000,
        B_OUT  = 7'b1000000
    } bstate_t;

    logic [32:0]            mem [RD];
    logic [32:0]            rd_data;
    logic [AW-1:0]          rd_addr;

    bstate_t                state_reg, state_next;
    job_t                   job_reg;
    logic [RBW+WW-1:0]      rw_reg;
    logic [AW-1:0]          rowbase_reg;
    logic signed [DB-1:0]   dy_reg, dx_reg;
    logic signed [SW-1:0]   sum_reg;
    logic [CNW-1:0]         cnt_reg;
    logic                   any_reg, acc_v_reg, acc_in_reg;
    logic                   neg_reg;
    logic [SW-1:0]          quo_reg;
    logic [CNW:0]           rem_reg;
    logic [DCW-1:0]         dstep_reg;
    logic [31:0]            val_reg;
    logic [1:0]             status_reg;

    logic signed [DB-1:0]   r_s;
    logic signed [HW+1:0]   ny;
    logic signed [WW+1:0]   nx;
    logic signed [2*DB:0]   dx_w, dy_w, r_w;
    logic [2*DB:0]          dist_sq, rr;
    logic                   in_win, scan_end;
    logic [CNW+1:0]         trial;
    logic [SW-1:0]          mag;

    assign r_s = $signed({1'b0, cfg.r});
    assign ny  = $signed({2'b0, job_reg.row}) + (HW+2)'(dy_reg);
    assign nx  = $signed((WW+2)'(job_reg.col)) + (WW+2)'(dx_reg);
    // Offsets are widened before squaring so that a square of sixteen still fits.
    assign dx_w    = (2*DB+1)'(dx_reg);
    assign dy_w    = (2*DB+1)'(dy_reg);
    assign r_w     = (2*DB+1)'(r_s);
    assign dist_sq = $unsigned(dx_w * dx_w) + $unsigned(dy_w * dy_w);
    assign rr      = $unsigned(r_w * r_w);
    assign in_win = (ny >= 0) && (ny < $signed({2'b0, cfg.h}))
                 && (nx >= 0) && (nx < $signed({2'b0, cfg.w}))
                 && (!cfg.circ || (dist_sq <= rr));
    assign scan_end = (dy_reg == r_s) && (dx_reg == r_s);

    always_comb
    begin
        if (state_reg == B_IDLE)
            rd_addr = job.addr;
        else
            rd_addr = rowbase_reg + AW'(dx_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        rd_data <= mem[rd_addr];
    end

    assign job_ready        = (state_reg == B_IDLE);
    assign out_ch.valid     = (state_reg == B_OUT);
    assign out_ch.out_value = val_reg;
    assign out_ch.out_status = status_reg;
    assign out_ch.out_last  = job_reg.last;

    assign mag   = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
    assign trial = {rem_reg, quo_reg[SW-1]} - (CNW+2)'(cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (job_valid) state_next = B_CTR;
            B_CTR:   state_next = rd_data[32] ? B_OUT : B_SCAN;
            B_SCAN:  if (scan_end) state_next = B_LAST;
            B_LAST:  state_next = B_FIN;
            B_FIN:   state_next = ((cnt_reg != '0) && any_reg) ? B_DIV : B_OUT;
            B_DIV:   if (dstep_reg == DCW'(SW - 1)) state_next = B_OUT;
            B_OUT:   if (out_ch.ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            acc_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_v_reg <= (state_reg == B_SCAN);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_in_reg <= in_win;
        // Accumulate the entry read in the previous scan cycle.
        if (acc_v_reg && acc_in_reg)
        begin
            if (rd_data[32])
            begin
                sum_reg <= sum_reg + SW'($signed(rd_data[31:0]));
                cnt_reg <= cnt_reg + 1'b1;
                any_reg <= 1'b1;
            end
            else if (cfg.den)
            begin
                sum_reg <= sum_reg + SW'($signed(cfg.dval));
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        unique case (state_reg)
            B_IDLE:
            begin
                job_reg <= job;
                rw_reg  <= (RBW+WW)'(cfg.r * cfg.w);
            end
            B_CTR:
            begin
                rowbase_reg <= job_reg.addr - AW'(rw_reg);
                dy_reg      <= -r_s;
                dx_reg      <= -r_s;
                sum_reg     <= '0;
                cnt_reg     <= '0;
                any_reg     <= 1'b0;
                val_reg     <= rd_data[31:0];
                status_reg  <= ST_COPIED;
            end
            B_SCAN:
            begin
                if (dx_reg == r_s)
                begin
                    dx_reg      <= -r_s;
                    dy_reg      <= dy_reg + 1'b1;
                    rowbase_reg <= rowbase_reg + AW'(cfg.w);
                end
                else
                begin
                    dx_reg <= dx_reg + 1'b1;
                end
            end
            B_LAST:
            begin
                dstep_reg <= '0;
            end
            B_FIN:
            begin
                // Rounding to nearest, ties away from zero, on the magnitude.
                neg_reg    <= sum_reg[SW-1];
                quo_reg    <= mag + SW'(cnt_reg >> 1);
                rem_reg    <= '0;
                val_reg    <= cfg.bval;
                status_reg <= ST_BAD;
            end
            B_DIV:
            begin
                dstep_reg <= dstep_reg + 1'b1;
                if (!trial[CNW+1])
                begin
                    rem_reg <= trial[CNW:0];
                    quo_reg <= {quo_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[CNW-1:0], quo_reg[SW-1]};
                    quo_reg <= {quo_reg[SW-2:0], 1'b0};
                end
                if (dstep_reg == DCW'(SW - 1))
                begin
                    status_reg <= ST_FILLED;
                    if (!trial[CNW+1])
                        val_reg <= neg_reg ? 32'(-{quo_reg[SW-2:0], 1'b1})
                                           : 32'({quo_reg[SW-2:0], 1'b1});
                    else
                        val_reg <= neg_reg ? 32'(-{quo_reg[SW-2:0], 1'b0})
                                           : 32'({quo_reg[SW-2:0], 1'b0});
                end
            end
            B_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ tb/grid_hole_fill_mean_tb.sv @@
// Testbench for grid_hole_fill_mean: directed frames and random frames of samples and drains,
// checked beat by beat against a predictor of the hole filler kept inside this file.
// Depends on ghfm_pkg, the ghfm_in_if and ghfm_out_if interfaces and the block itself.
`timescale 1ns / 1ps

module grid_hole_fill_mean_tb;
    import ghfm_pkg::*;

    localparam logic CMD_DRAIN  = 1'b1;
    localparam int   STORE_LEN  = (MAX_WIDTH + 1) * (2 * MAX_RADIUS + 1);
    localparam int   SETTLE_CYC = 400;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  status;
        logic        last;
    } fill_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ghfm_in_if  in_ch ();
    ghfm_out_if out_ch ();

    grid_hole_fill_mean dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Predictor state: the line store ring, positions and the register copies.
    logic [32:0]  grid_store [STORE_LEN];
    int unsigned  store_wr, store_rd, backlog;
    int unsigned  in_col, in_row, out_col, out_row;
    int unsigned  cfg_width, cfg_height, cfg_radius;
    bit           cfg_circ, cfg_den;
    logic [31:0]  cfg_dval, cfg_bval;

    fill_result_t due_results[$];
    int           mismatches;
    int           samples_sent;
    bit           quiet;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("grid_hole_fill_mean_tb: done, errors");
        $finish;
    end

    function automatic int unsigned eff_width();
        if (cfg_width < 1) return 1;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_height < 1) ? 1 : cfg_height;
    endfunction

    function automatic int unsigned eff_radius();
        if (cfg_radius < 1) return 1;
        if (cfg_radius > MAX_RADIUS) return MAX_RADIUS;
        return cfg_radius;
    endfunction

    function automatic bit result_due();
        longint w, h, r, idx, last_idx, need, rem;
        w = eff_width();
        h = eff_height();
        r = eff_radius();
        idx = longint'(out_row) * w + out_col;
        last_idx = h * w - 1;
        need = r * w + r;
        rem = (idx > last_idx) ? 0 : last_idx - idx;
        if (rem < need) need = rem;
        return longint'(backlog) >= need + 1;
    endfunction

    function automatic fill_result_t fill_next();
        fill_result_t res;
        int w, h, r, dx, dy, ny, nx, cnt;
        longint sum, mag, q;
        bit any_valid;
        logic [32:0] e;
        w = eff_width();
        h = eff_height();
        r = eff_radius();
        e = grid_store[store_rd];
        if (e[32]) begin
            res.value  = e[31:0];
            res.status = ST_COPIED;
        end else begin
            sum = 0;
            cnt = 0;
            any_valid = 0;
            for (dy = -r; dy <= r; dy++) begin
                ny = int'(out_row) + dy;
                if (ny < 0 || ny >= h) continue;
                for (dx = -r; dx <= r; dx++) begin
                    nx = int'(out_col) + dx;
                    if (nx < 0 || nx >= w) continue;
                    if (cfg_circ && dx * dx + dy * dy > r * r) continue;
                    e = grid_store[(int'(store_rd) + STORE_LEN + dy * w + dx) % STORE_LEN];
                    if (e[32]) begin
                        any_valid = 1;
                        sum += longint'(signed'(e[31:0]));
                        cnt++;
                    end else if (cfg_den) begin
                        sum += longint'(signed'(cfg_dval));
                        cnt++;
                    end
                end
            end
            if (cnt > 0 && any_valid) begin
                // Round to nearest with ties away from zero.
                mag = (sum < 0) ? -sum : sum;
                q = (mag + cnt / 2) / cnt;
                if (sum < 0) q = -q;
                res.value  = q[31:0];
                res.status = ST_FILLED;
            end else begin
                res.value  = cfg_bval;
                res.status = ST_BAD;
            end
        end
        res.last = (out_col + 1 >= w && out_row + 1 >= h);
        if (out_col + 1 >= w) begin
            out_col = 0;
            out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
        end else begin
            out_col++;
        end
        store_rd = (store_rd + 1) % STORE_LEN;
        backlog--;
        return res;
    endfunction

    function automatic void predict_beat(logic cmd, logic [31:0] val, logic vld);
        if (cmd == CMD_SAMPLE) begin
            grid_store[store_wr] = {vld, val};
            store_wr = (store_wr + 1) % STORE_LEN;
            backlog++;
            if (in_col + 1 >= eff_width()) begin
                in_col = 0;
                in_row = (in_row + 1 >= eff_height()) ? 0 : in_row + 1;
            end else begin
                in_col++;
            end
        end
        if (backlog > 0 && result_due())
            due_results.push_back(fill_next());
    endfunction

    // Called just after a rising edge; returns just after the edge that accepts the beat.
    task automatic send_beat(logic cmd, logic [31:0] val, logic vld);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.command      <= cmd;
        in_ch.sample_value <= val;
        in_ch.sample_valid <= vld;
        do @(posedge clk); while (!in_ch.ready);
        predict_beat(cmd, val, vld);
        if (cmd == CMD_SAMPLE) samples_sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:     cfg_width  = 32'(data[10:0]);
            REG_GRID_HEIGHT:    cfg_height = 32'(data[15:0]);
            REG_RADIUS:         cfg_radius = 32'(data[2:0]);
            REG_CIRCULAR_MODE:  cfg_circ   = data[0];
            REG_DEFAULT_ENABLE: cfg_den    = data[0];
            REG_DEFAULT_VALUE:  cfg_dval   = data;
            REG_BAD_VALUE:      cfg_bval   = data;
            default: ;
        endcase
    endtask

    // Drain the tail of the frame, then let the back end finish any busy work.
    task automatic flush_and_settle();
        while (backlog > 0)
            send_beat(CMD_DRAIN, $urandom, 1'($urandom_range(0, 1)));
        in_ch.valid <= 1'b0;
        while (due_results.size() > 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_frame(int w, int h, int r, bit circ, bit den,
                             logic [31:0] dval, logic [31:0] bval);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_RADIUS, r);
        write_reg(REG_CIRCULAR_MODE, 32'(circ));
        write_reg(REG_DEFAULT_ENABLE, 32'(den));
        write_reg(REG_DEFAULT_VALUE, dval);
        write_reg(REG_BAD_VALUE, bval);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1:       return $urandom_range(0, 40) - 20;
            default: return $urandom;
        endcase
    endfunction

    // Valid centres pass through; a centre with no valid neighbour takes the bad value.
    task automatic test_copy_and_bad();
        set_frame(3, 1, 0, 1'b0, 1'b0, 32'h0, 32'h8000_0000);
        send_beat(CMD_DRAIN, 32'h0, 1'b0);
        send_beat(CMD_SAMPLE, 32'h7FFF_FFFF, 1'b1);
        send_beat(CMD_SAMPLE, 32'hFFFF_FFFF, 1'b0);
        send_beat(CMD_SAMPLE, 32'h8000_0000, 1'b1);
        flush_and_settle();
        set_frame(2, 1, 1, 1'b0, 1'b0, 32'h0, 32'h7FFF_FFFF);
        send_beat(CMD_SAMPLE, 32'h1234_5678, 1'b0);
        send_beat(CMD_SAMPLE, 32'h0, 1'b0);
        flush_and_settle();
    endtask

    // Halves round away from zero on both signs.
    task automatic test_rounding();
        set_frame(6, 1, 1, 1'b0, 1'b0, 32'h0, 32'h0);
        send_beat(CMD_SAMPLE, -32'sd1, 1'b1);
        send_beat(CMD_SAMPLE, 32'h0, 1'b0);
        send_beat(CMD_SAMPLE, -32'sd2, 1'b1);
        send_beat(CMD_SAMPLE, 32'd1, 1'b1);
        send_beat(CMD_SAMPLE, 32'h0, 1'b0);
        send_beat(CMD_SAMPLE, 32'd2, 1'b1);
        flush_and_settle();
    endtask

    // Circular window with default substitution and drains that arrive too early.
    task automatic test_circular_default();
        set_frame(3, 3, 1, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h5);
        for (int i = 0; i < 9; i++) begin
            send_beat(CMD_SAMPLE, 32'h0001_0000, i == 4);
            if (i == 2) send_beat(CMD_DRAIN, 32'h0, 1'b0);
        end
        flush_and_settle();
    endtask

    // Out-of-range registers: zero width and height, radius above the maximum.
    task automatic test_register_clamp();
        set_frame(0, 0, 7, 1'b0, 1'b1, 32'h8000_0000, 32'hDEAD_BEEF);
        send_beat(CMD_SAMPLE, 32'h0, 1'b0);
        flush_and_settle();
        set_frame(4, 3, 7, 1'b0, 1'b1, 32'h8000_0000, 32'h0);
        for (int i = 0; i < 12; i++)
            send_beat(CMD_SAMPLE, random_value(), i % 3 == 0);
        flush_and_settle();
    endtask

    task automatic test_random_frames();
        int w, h, pct;
        while (samples_sent < 500) begin
            quiet = ($urandom_range(0, 4) == 0);
            w = $urandom_range(0, 12);
            h = $urandom_range(0, 6);
            pct = ($urandom_range(0, 2) == 0) ? 20 : ($urandom_range(0, 1) ? 50 : 90);
            set_frame(w, h, $urandom_range(0, 7), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), random_value(), random_value());
            for (int i = 0; i < eff_width() * eff_height(); i++) begin
                if ($urandom_range(0, 19) == 0)
                    send_beat(CMD_DRAIN, $urandom, 1'($urandom_range(0, 1)));
                send_beat(CMD_SAMPLE, random_value(), $urandom_range(1, 100) <= pct);
            end
            flush_and_settle();
        end
        quiet = 0;
    endtask

    // Result side: random stall before each beat, then check it against the oldest prediction.
    initial
    begin
        int stall;
        fill_result_t exp_res;
        bit bad;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: value %h status %0d last %0b",
                             out_ch.out_value, out_ch.out_status, out_ch.out_last);
            end else begin
                exp_res = due_results.pop_front();
                bad = (out_ch.out_value !== exp_res.value) ||
                      (out_ch.out_status !== exp_res.status) ||
                      (out_ch.out_last !== exp_res.last);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                                 exp_res.value, exp_res.status, exp_res.last,
                                 out_ch.out_value, out_ch.out_status, out_ch.out_last);
                end
            end
        end
    end

    initial
    begin
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.command      <= CMD_SAMPLE;
        in_ch.sample_value <= '0;
        in_ch.sample_valid <= 1'b0;
        for (int i = 0; i < STORE_LEN; i++) grid_store[i] = '0;
        store_wr = 0;
        store_rd = 0;
        backlog = 0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        cfg_width = 1024;
        cfg_height = 1;
        cfg_radius = 1;
        cfg_circ = 0;
        cfg_den = 0;
        cfg_dval = '0;
        cfg_bval = '0;
        mismatches = 0;
        samples_sent = 0;
        quiet = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_copy_and_bad();
        test_rounding();
        test_circular_default();
        test_register_clamp();
        test_random_frames();

        while (due_results.size() > 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        if (mismatches == 0)
            $display("grid_hole_fill_mean_tb: done, clean");
        else
            $display("grid_hole_fill_mean_tb: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
src/ghfm_pkg.sv
src/ghfm_if.sv
src/ghfm_front.sv
src/ghfm_queue.sv
src/ghfm_back.sv
src/grid_hole_fill_mean.sv
tb/grid_hole_fill_mean_tb.sv
